// ===== src/g2p_pkg.sv =====
// Shared types, constants and glyph tables for the doubled-height text renderer.
// No dependencies; every other file in src imports this package.
package g2p_pkg;

  // Input item kinds (carried on in_tuser)
  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_CHAR  = 1'b1;

  // Output byte kinds (carried on out_tuser)
  localparam logic BYTE_CMD  = 1'b0;
  localparam logic BYTE_DATA = 1'b1;

  // Field widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int COL_W       = 7;
  localparam int CURCOL_W    = 8;
  localparam int PAGE_W      = 3;
  localparam int CODE_W      = 8;
  localparam int GIDX_W      = 4;
  localparam int STEP_W      = 5;

  // Display command bytes and cursor constants
  localparam logic [7:0]          PAGE_CMD    = 8'hB0;
  localparam logic [7:0]          COL_HI_CMD  = 8'h10;
  localparam logic [CURCOL_W-1:0] LAST_COLUMN = 8'd119;
  localparam logic [CURCOL_W-1:0] COLUMN_STEP = 8'd9;
  localparam logic [CODE_W-1:0]   CODE_NUL    = 8'h00;

  // Run layout: per half three commands then eight data bytes
  localparam logic [STEP_W-1:0] HALF_LEN  = 5'd11;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd21;
  localparam logic [3:0]        STEP_PAGE = 4'd0;
  localparam logic [3:0]        STEP_CLO  = 4'd1;
  localparam logic [3:0]        STEP_CHI  = 4'd2;
  localparam logic [3:0]        STEP_DATA = 4'd3;

  // Default depth of the job queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Glyph table indexes
  localparam logic [GIDX_W-1:0] G_BLANK = 4'd0;
  localparam logic [GIDX_W-1:0] G_A     = 4'd1;
  localparam logic [GIDX_W-1:0] G_C     = 4'd2;
  localparam logic [GIDX_W-1:0] G_E     = 4'd3;
  localparam logic [GIDX_W-1:0] G_H     = 4'd4;
  localparam logic [GIDX_W-1:0] G_I     = 4'd5;
  localparam logic [GIDX_W-1:0] G_L     = 4'd6;
  localparam logic [GIDX_W-1:0] G_M     = 4'd7;
  localparam logic [GIDX_W-1:0] G_N     = 4'd8;
  localparam logic [GIDX_W-1:0] G_O     = 4'd9;
  localparam logic [GIDX_W-1:0] G_P     = 4'd10;
  localparam logic [GIDX_W-1:0] G_R     = 4'd11;
  localparam logic [GIDX_W-1:0] G_S     = 4'd12;
  localparam logic [GIDX_W-1:0] G_T     = 4'd13;
  localparam logic [GIDX_W-1:0] G_W     = 4'd14;

  // One rendering job handed from front to back
  typedef struct packed {
    logic [GIDX_W-1:0] gidx;
    logic [COL_W-1:0]  column;
    logic [PAGE_W-1:0] page;
  } g2p_job_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } g2p_qstat_t;

  // Back-end sequencer status
  typedef struct packed {
    logic active;
    logic step_zero;
  } g2p_bstat_t;

  // Map a character code to its glyph; anything unknown is blank
  function automatic logic [GIDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
    logic [GIDX_W-1:0] g;
    case (code)
      8'h41:   g = G_A;  // 'A'
      8'h43:   g = G_C;  // 'C'
      8'h45:   g = G_E;  // 'E'
      8'h48:   g = G_H;  // 'H'
      8'h49:   g = G_I;  // 'I'
      8'h4C:   g = G_L;  // 'L'
      8'h4D:   g = G_M;  // 'M'
      8'h4E:   g = G_N;  // 'N'
      8'h4F:   g = G_O;  // 'O'
      8'h50:   g = G_P;  // 'P'
      8'h52:   g = G_R;  // 'R'
      8'h53:   g = G_S;  // 'S'
      8'h54:   g = G_T;  // 'T'
      8'h57:   g = G_W;  // 'W'
      default: g = G_BLANK;
    endcase
    return g;
  endfunction

  // Glyph bitmap: row r at bits [8r+7:8r], bit 7 of a row is the leftmost pixel
  function automatic logic [63:0] glyph_rows(input logic [GIDX_W-1:0] gidx);
    logic [63:0] rows;
    case (gidx)
      G_A:     rows = 64'h00_42_42_42_7E_42_42_3C;
      G_C:     rows = 64'h00_3C_42_40_40_40_42_3C;
      G_E:     rows = 64'h00_7E_40_40_7C_40_40_7E;
      G_H:     rows = 64'h00_42_42_42_7E_42_42_42;
      G_I:     rows = 64'h00_7E_18_18_18_18_18_7E;
      G_L:     rows = 64'h00_7E_40_40_40_40_40_40;
      G_M:     rows = 64'h00_42_42_42_5A_5A_66_42;
      G_N:     rows = 64'h00_42_42_46_4A_52_62_42;
      G_O:     rows = 64'h00_3C_42_42_42_42_42_3C;
      G_P:     rows = 64'h00_40_40_40_7C_42_42_7C;
      G_R:     rows = 64'h00_42_44_48_7C_42_42_7C;
      G_S:     rows = 64'h00_3C_42_02_3C_40_42_3C;
      G_T:     rows = 64'h00_18_18_18_18_18_18_7E;
      G_W:     rows = 64'h00_42_66_5A_5A_42_42_42;
      default: rows = 64'h0;
    endcase
    return rows;
  endfunction

endpackage

// ===== src/glyph_to_page_column_renderer.sv =====
// Top level of the doubled-height text renderer for a page-addressed display.
// Depends on g2p_pkg, g2p_front, g2p_queue and g2p_back.
//
//   port group | dir | contents
//   in_*       | in  | tuser: kind; tdata: start_column[6:0], start_page[9:7],
//              |     |        char_code[17:10], zero pad [23:18]
//   out_*      | out | tuser: is_data; tdata: out_byte[7:0]; tlast: last
//
// A drawn character gives 22 bytes from the back end's byte sequencer, one output
// byte per cycle while the output is not stalled; runs of consecutive characters
// follow without gaps. Begin items, NUL codes and dropped characters give none.
// An accepted character passes the job queue and the job register before its
// first byte is registered. Reset is synchronous; the block is ready after reset.
// Output stalls fill the job queue; input stalls only while the queue is full.
module glyph_to_page_column_renderer
  import g2p_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // start_column, start_page, char_code
  input  logic                   in_tuser,   // kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_byte
  output logic                   out_tuser,  // is_data
  output logic                   out_tlast
);

  g2p_qstat_t q_stat;
  g2p_bstat_t b_stat;
  g2p_job_t   push_job;
  g2p_job_t   pop_job;
  logic       q_push;
  logic       q_pop;

  g2p_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  g2p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  g2p_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .stat       (b_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Only an accepted character item may queue a job
  a_push_on_char: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_tvalid && in_tready && in_tuser == KIND_CHAR))
    else $error("job queued without an accepted character");

  // A waiting final byte means the sequencer has wrapped to its first step
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> b_stat.step_zero)
    else $error("sequencer not wrapped after final byte");

  // The final byte of a run is always a pixel byte
  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == BYTE_DATA))
    else $error("final byte flagged as command");

  // Queue cannot be full and empty at once
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

endmodule

// ===== src/g2p_front.sv =====
// Front end: accepts input items, keeps the cursor and stop mark, and queues render jobs.
// Depends on g2p_pkg.
module g2p_front
  import g2p_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  g2p_qstat_t            q_stat,
  output logic                  q_push,
  output g2p_job_t              q_job
);

  logic [CURCOL_W-1:0] column_r, column_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic                stopped_r, stopped_nxt;
  logic                accept;
  logic [COL_W-1:0]    start_column;
  logic [PAGE_W-1:0]   start_page;
  logic [CODE_W-1:0]   char_code;

  // Unpack the input transfer
  assign start_column = in_tdata[COL_W-1:0];
  assign start_page   = in_tdata[COL_W+PAGE_W-1:COL_W];
  assign char_code    = in_tdata[COL_W+PAGE_W+CODE_W-1:COL_W+PAGE_W];

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Job position comes straight from the current cursor, the glyph from the character code
  assign q_job.gidx   = glyph_index(char_code);
  assign q_job.column = column_r[COL_W-1:0];
  assign q_job.page   = page_r;

  // Classify the item and update the cursor
  always_comb begin
    column_nxt  = column_r;
    page_nxt    = page_r;
    stopped_nxt = stopped_r;
    q_push      = 1'b0;
    if (accept) begin
      if (in_tuser == KIND_BEGIN) begin
        column_nxt  = {1'b0, start_column};
        page_nxt    = start_page;
        stopped_nxt = 1'b0;
      end else if (!stopped_r && column_r <= LAST_COLUMN) begin
        if (char_code == CODE_NUL) begin
          stopped_nxt = 1'b1;
        end else begin
          q_push     = 1'b1;
          column_nxt = column_r + COLUMN_STEP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r  <= '0;
      page_r    <= '0;
      stopped_r <= 1'b0;
    end else begin
      column_r  <= column_nxt;
      page_r    <= page_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// ===== src/g2p_queue.sv =====
// Short job queue between the front end and the byte sequencer.
// Depends on g2p_pkg.
module g2p_queue
  import g2p_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  g2p_job_t   push_job,
  input  logic       pop,
  output g2p_job_t   pop_job,
  output g2p_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  g2p_job_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_job    = mem[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the job
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== src/g2p_back.sv =====
// Back end: steps through the 22-byte run of one job and drives the output register.
// Depends on g2p_pkg.
module g2p_back
  import g2p_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  g2p_qstat_t             q_stat,
  input  g2p_job_t               q_job,
  output logic                   q_pop,
  output g2p_bstat_t             stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  g2p_job_t                job_r;
  logic                    active_r, active_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0]  byte_r;
  logic                    is_data_r;
  logic                    last_r;
  logic                    advance;
  logic                    at_last;
  logic                    half;
  logic [STEP_W-1:0]       in_half;
  logic [3:0]              k;
  logic [2:0]              pix_col;
  logic [63:0]             rows;
  logic [7:0]              data_byte;
  logic [7:0]              byte_nxt;
  logic                    is_data_nxt;

  assign advance = active_r && (!valid_r || out_tready);
  assign at_last = (step_r == LAST_STEP);
  assign q_pop   = !q_stat.empty && (!active_r || (advance && at_last));

  assign stat.active    = active_r;
  assign stat.step_zero = (step_r == '0);

  // Decode the step into half, position within the half and pixel column
  assign half    = (step_r >= HALF_LEN);
  assign in_half = half ? step_r - HALF_LEN : step_r;
  assign k       = in_half[3:0];
  assign pix_col = 3'(k - STEP_DATA);
  assign rows    = glyph_rows(job_r.gidx);

  // Double each of the four glyph rows of this half into two pixel bits
  always_comb begin
    data_byte = '0;
    for (int r = 0; r < 4; r++) begin
      data_byte[2*r]   = rows[(half ? 32 : 0) + 8*r + 7 - int'(pix_col)];
      data_byte[2*r+1] = rows[(half ? 32 : 0) + 8*r + 7 - int'(pix_col)];
    end
  end

  // Select the byte for this step
  always_comb begin
    is_data_nxt = BYTE_CMD;
    case (k)
      STEP_PAGE: byte_nxt = PAGE_CMD + {5'b0, job_r.page} + {7'b0, half};
      STEP_CLO:  byte_nxt = {4'b0, job_r.column[3:0]};
      STEP_CHI:  byte_nxt = COL_HI_CMD + {5'b0, job_r.column[COL_W-1:4]};
      default: begin
        byte_nxt    = data_byte;
        is_data_nxt = BYTE_DATA;
      end
    endcase
  end

  // Sequencer control and output valid
  always_comb begin
    active_nxt = active_r;
    step_nxt   = step_r;
    valid_nxt  = valid_r;
    if (advance) begin
      step_nxt  = at_last ? '0 : step_r + 1'b1;
      valid_nxt = 1'b1;
      if (at_last) begin
        active_nxt = 1'b0;
      end
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
    if (q_pop) begin
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= '0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      step_r   <= step_nxt;
      valid_r  <= valid_nxt;
    end
  end

  // Hold the job and the output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (advance) begin
      byte_r    <= byte_nxt;
      is_data_r <= is_data_nxt;
      last_r    <= at_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = is_data_r;
  assign out_tlast  = last_r;

endmodule
